// ===== rtl/pclc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclc_pkg
// Shared types, codes and constants of the pedestrian crossing controller.
// ----------------------------------------------------------------------------
package pclc_pkg;

    // tick timer width, saturating counter
    localparam int TIMER_WIDTH = 16;
    localparam int LEN_WIDTH   = 16;
    // compare width: wide enough for timer + 1 and any length value
    localparam int CMP_W = ((TIMER_WIDTH > LEN_WIDTH) ? TIMER_WIDTH : LEN_WIDTH) + 1;

    localparam int WALK_WIDTH = 7;
    localparam logic [WALK_WIDTH-1:0] WALK_MAX = 7'd99;

    // phase codes
    localparam logic [1:0] PH_GO    = 2'd0;
    localparam logic [1:0] PH_AMBER = 2'd1;
    localparam logic [1:0] PH_WALK  = 2'd2;
    localparam logic [1:0] PH_HOLD  = 2'd3;

    // register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_AMBER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_ON  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_OFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WALK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd4;

    // reset values
    localparam logic [LEN_WIDTH-1:0]  AMBER_RST    = 16'd2000;
    localparam logic [LEN_WIDTH-1:0]  BEEP_ON_RST  = 16'd250;
    localparam logic [LEN_WIDTH-1:0]  BEEP_OFF_RST = 16'd750;
    localparam logic [WALK_WIDTH-1:0] WALK_RST     = 7'd20;
    localparam logic [LEN_WIDTH-1:0]  HOLD_RST     = 16'd20000;

    typedef struct packed {
        logic       digit_select;
        logic [7:0] segments;
    } disp_t;

    // active-low seven-segment patterns, dp off
    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'hC0;
            4'd1:    pat = 8'hF9;
            4'd2:    pat = 8'hA4;
            4'd3:    pat = 8'hB0;
            4'd4:    pat = 8'h99;
            4'd5:    pat = 8'h92;
            4'd6:    pat = 8'h82;
            4'd7:    pat = 8'hF8;
            4'd8:    pat = 8'h80;
            4'd9:    pat = 8'h98;
            default: pat = 8'hFF;
        endcase
        return pat;
    endfunction

endpackage

// ===== rtl/pedestrian_crossing_light_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedestrian_crossing_light_controller
// Car / pedestrian crossing light sequencer driven by a 1 ms tick stream.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall / button_press): one transfer is one
//    1 ms tick; button_press flags a button edge seen during that tick.
//  - Output channel (out_valid / out_stall / lamp and display fields): one
//    transfer per input tick, showing the state at the start of that tick.
//  - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//    ready; index 0 amber, 1 beep on, 2 beep off, 3 walk count, 4 hold.
//    Other indexes are dropped. Write only while the block is idle.
//  - Result: registered; it appears in the cycle after the tick transfer.
//  - Throughput: one tick per cycle while the output is not stalled;
//    next-state logic is a compare, increment and mux into the state registers.
//  - Stall: the output register holds its result; in_stall is raised only
//    while that register is full and stalled, so a tick is taken in the same
//    cycle the pending result leaves.
//  - Reset: car go phase, no request, timers cleared, register defaults
//    loaded, output register empty.
// ----------------------------------------------------------------------------
module pedestrian_crossing_light_controller
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        button_press,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        car_green,
    output logic        car_amber,
    output logic        car_red,
    output logic        walk_green,
    output logic        walk_red,
    output logic        buzzer_on,
    output logic        digit_select,
    output logic [7:0]  segments,
    output logic [1:0]  phase_code,
    output logic [6:0]  countdown,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int TW = pclc_pkg::TIMER_WIDTH;
    localparam int LW = pclc_pkg::LEN_WIDTH;
    localparam int CW = pclc_pkg::CMP_W;
    localparam int WW = pclc_pkg::WALK_WIDTH;

    // config registers
    logic [LW-1:0] amber_ticks_reg, beep_on_ticks_reg, beep_off_ticks_reg, hold_ticks_reg;
    logic [WW-1:0] walk_count_reg;

    // sequencer state
    logic [1:0]    phase_reg, phase_next;
    logic          request_reg, request_next;
    logic [TW-1:0] timer_reg, timer_next;
    logic [WW-1:0] seconds_reg, seconds_next;
    logic          beep_part_reg, beep_part_next;
    logic          toggle_reg;

    // output register
    logic          out_valid_reg;
    logic          car_green_reg, car_amber_reg, car_red_reg;
    logic          walk_green_reg, walk_red_reg, buzzer_reg;
    logic          digit_select_reg;
    logic [7:0]    segments_reg;
    logic [1:0]    phase_code_reg;
    logic [6:0]    countdown_reg;

    logic            accept;
    logic            is_walk;
    logic [WW-1:0]   sec_shown;
    logic [WW-1:0]   walk_load;
    logic [LW-1:0]   part_len;
    logic [CW-1:0]   timer_inc;
    logic            part_done;
    pclc_pkg::disp_t disp;

    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amber_ticks_reg    <= pclc_pkg::AMBER_RST;
            beep_on_ticks_reg  <= pclc_pkg::BEEP_ON_RST;
            beep_off_ticks_reg <= pclc_pkg::BEEP_OFF_RST;
            walk_count_reg     <= pclc_pkg::WALK_RST;
            hold_ticks_reg     <= pclc_pkg::HOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pclc_pkg::CFG_AMBER:    amber_ticks_reg    <= cfg_data;
                pclc_pkg::CFG_BEEP_ON:  beep_on_ticks_reg  <= cfg_data;
                pclc_pkg::CFG_BEEP_OFF: beep_off_ticks_reg <= cfg_data;
                pclc_pkg::CFG_WALK:     walk_count_reg     <= cfg_data[WW-1:0];
                pclc_pkg::CFG_HOLD:     hold_ticks_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result fields from the current state
    // ------------------------------------------------------------------
    assign is_walk   = (phase_reg == pclc_pkg::PH_WALK);
    assign sec_shown = (seconds_reg > pclc_pkg::WALK_MAX) ? pclc_pkg::WALK_MAX : seconds_reg;

    pclc_display u_display
    (
        .seconds   (sec_shown),
        .units_sel (toggle_reg),
        .disp      (disp)
    );

    // ------------------------------------------------------------------
    // phase sequencer
    // ------------------------------------------------------------------
    // length of the part being timed; only one part runs at a time
    always_comb
    begin
        case (phase_reg)
            pclc_pkg::PH_AMBER: part_len = amber_ticks_reg;
            pclc_pkg::PH_WALK:  part_len = beep_part_reg ? beep_off_ticks_reg
                                                         : beep_on_ticks_reg;
            default:            part_len = hold_ticks_reg;
        endcase
    end

    // zero length acts as one tick; saturated timer also ends the part
    assign timer_inc = CW'(timer_reg) + CW'(1);
    assign part_done = (timer_inc >= CW'(part_len)) || (timer_reg == {TW{1'b1}});

    // walk count: zero acts as one, above 99 clamps
    assign walk_load = (walk_count_reg == '0) ? WW'(1) :
                       (walk_count_reg > pclc_pkg::WALK_MAX) ? pclc_pkg::WALK_MAX :
                       walk_count_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        request_next   = request_reg | button_press;
        timer_next     = timer_reg;
        seconds_next   = seconds_reg;
        beep_part_next = beep_part_reg;

        case (phase_reg)
            pclc_pkg::PH_GO:
            begin
                if (request_next)
                begin
                    phase_next = pclc_pkg::PH_AMBER;
                    timer_next = '0;
                end
            end
            pclc_pkg::PH_AMBER:
            begin
                timer_next = part_done ? '0 : timer_inc[TW-1:0];
                if (part_done)
                begin
                    seconds_next   = walk_load;
                    beep_part_next = 1'b0;
                    phase_next     = pclc_pkg::PH_WALK;
                end
            end
            pclc_pkg::PH_WALK:
            begin
                timer_next = part_done ? '0 : timer_inc[TW-1:0];
                if (part_done)
                begin
                    if (!beep_part_reg)
                    begin
                        beep_part_next = 1'b1;
                    end
                    else
                    begin
                        // end of one walk second
                        beep_part_next = 1'b0;
                        if (seconds_reg <= WW'(1))
                        begin
                            seconds_next = '0;
                            request_next = 1'b0;
                            phase_next   = pclc_pkg::PH_HOLD;
                        end
                        else
                        begin
                            seconds_next = seconds_reg - WW'(1);
                        end
                    end
                end
            end
            default:
            begin
                timer_next = part_done ? '0 : timer_inc[TW-1:0];
                if (part_done)
                begin
                    phase_next = pclc_pkg::PH_GO;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pclc_pkg::PH_GO;
            request_reg   <= 1'b0;
            timer_reg     <= '0;
            seconds_reg   <= '0;
            beep_part_reg <= 1'b0;
            toggle_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            request_reg   <= request_next;
            timer_reg     <= timer_next;
            seconds_reg   <= seconds_next;
            beep_part_reg <= beep_part_next;
            toggle_reg    <= ~toggle_reg;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload: lamps and display reflect state before this tick's update
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            car_green_reg    <= (phase_reg == pclc_pkg::PH_GO) ||
                                (phase_reg == pclc_pkg::PH_HOLD);
            car_amber_reg    <= (phase_reg == pclc_pkg::PH_AMBER);
            car_red_reg      <= is_walk;
            walk_green_reg   <= is_walk;
            walk_red_reg     <= ~is_walk;
            buzzer_reg       <= is_walk & ~beep_part_reg;
            digit_select_reg <= disp.digit_select;
            segments_reg     <= disp.segments;
            phase_code_reg   <= phase_reg;
            countdown_reg    <= sec_shown;
        end
    end

    assign out_valid    = out_valid_reg;
    assign car_green    = car_green_reg;
    assign car_amber    = car_amber_reg;
    assign car_red      = car_red_reg;
    assign walk_green   = walk_green_reg;
    assign walk_red     = walk_red_reg;
    assign buzzer_on    = buzzer_reg;
    assign digit_select = digit_select_reg;
    assign segments     = segments_reg;
    assign phase_code   = phase_code_reg;
    assign countdown    = countdown_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with empty output register");

    a_one_car_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({car_green, car_amber, car_red}))
        else $error("car lamps not exclusive");

    a_seconds_range: assert property (@(posedge clk) disable iff (!rst_n)
        seconds_reg <= pclc_pkg::WALK_MAX)
        else $error("countdown out of range");

    a_walk_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pclc_pkg::PH_WALK || phase_reg == pclc_pkg::PH_AMBER) |-> request_reg)
        else $error("crossing phase without latched request");

    a_go_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pclc_pkg::PH_GO) |-> (timer_reg == '0))
        else $error("timer running in car go phase");

endmodule

// ===== rtl/pclc_display.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclc_display
// Splits the countdown into tens and units and encodes the selected digit.
// ----------------------------------------------------------------------------
module pclc_display
(
    input  logic [pclc_pkg::WALK_WIDTH-1:0] seconds,
    input  logic                            units_sel,
    output pclc_pkg::disp_t                 disp
);

    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units_full;
    logic [3:0]  digit;

    // x/10 == (x*205)>>11 for x <= 99
    assign prod       = 15'(seconds) * 15'd205;
    assign tens       = prod[14:11];
    assign units_full = 7'(seconds - 7'(tens) * 7'd10);
    assign digit      = units_sel ? units_full[3:0] : tens;

    assign disp.digit_select = units_sel;
    assign disp.segments     = pclc_pkg::seg_pattern(digit);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pedestrian crossing light controller.
// ----------------------------------------------------------------------------
// Every accepted tick goes through a behavioral copy of the light sequencer.
// That copy gives the lamp and display state expected for the tick. A
// checker compares each output transfer field by field with the oldest
// expected state. Directed tests cover reset, zero lengths, the walk clamp,
// presses during walk and hold, unused register indexes and full-scale
// lengths. Random phases follow, each with its own register setting. Both
// channels idle at random, except in random phase 1.
// ----------------------------------------------------------------------------
module testbench;

    // ------------------------------------------------------------------------
    // bench constants
    // ------------------------------------------------------------------------
    localparam int CYCLE_LIMIT   = 300000;  // generous bound on the whole run
    localparam int DRAIN_SLACK   = 3;       // the block registers its result once
    localparam int IDLE_PCT      = 27;      // chance of a gap / stall per cycle
    localparam int MAX_PRINTS    = 100;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_TICKS   = 174;

    // register indexes past the end of the map, must be dropped by the block
    localparam logic [pclc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd5;
    localparam logic [pclc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd6;
    localparam logic [pclc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_C = 3'd7;

    // one output transfer worth of lamp and display state
    typedef struct packed {
        logic       car_green;
        logic       car_amber;
        logic       car_red;
        logic       walk_green;
        logic       walk_red;
        logic       buzzer_on;
        logic       digit_select;
        logic [7:0] segments;
        logic [1:0] phase_code;
        logic [6:0] countdown;
    } lamp_state_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        button_press = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic        car_green;
    logic        car_amber;
    logic        car_red;
    logic        walk_green;
    logic        walk_red;
    logic        buzzer_on;
    logic        digit_select;
    logic [7:0]  segments;
    logic [1:0]  phase_code;
    logic [6:0]  countdown;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [pclc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data     = '0;

    pedestrian_crossing_light_controller uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .button_press (button_press),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .car_green    (car_green),
        .car_amber    (car_amber),
        .car_red      (car_red),
        .walk_green   (walk_green),
        .walk_red     (walk_red),
        .buzzer_on    (buzzer_on),
        .digit_select (digit_select),
        .segments     (segments),
        .phase_code   (phase_code),
        .countdown    (countdown),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // sequencer copy: register settings and state
    // ------------------------------------------------------------------------
    logic [pclc_pkg::LEN_WIDTH-1:0]   amber_len     = pclc_pkg::AMBER_RST;
    logic [pclc_pkg::LEN_WIDTH-1:0]   beep_len      = pclc_pkg::BEEP_ON_RST;
    logic [pclc_pkg::LEN_WIDTH-1:0]   quiet_len     = pclc_pkg::BEEP_OFF_RST;
    logic [pclc_pkg::WALK_WIDTH-1:0]  walk_secs_cfg = pclc_pkg::WALK_RST;
    logic [pclc_pkg::LEN_WIDTH-1:0]   hold_len      = pclc_pkg::HOLD_RST;

    logic [1:0]                       light_phase   = pclc_pkg::PH_GO;
    logic                             crossing_req  = 1'b0;
    logic [pclc_pkg::TIMER_WIDTH-1:0] tick_count    = '0;
    logic [pclc_pkg::WALK_WIDTH-1:0]  secs_left     = '0;
    logic                             in_silence    = 1'b0;  // second part of a second
    logic                             show_units    = 1'b0;

    lamp_state_t pending_lamps [$];   // expected transfers, oldest first

    // bookkeeping
    bit          no_idle         = 1'b0;  // both sides run flat out when set
    int unsigned err_count       = 0;
    int unsigned ticks_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned reg_writes      = 0;
    int unsigned cycle_count     = 0;
    int unsigned phase_ticks [4] = '{0, 0, 0, 0};

    // active-low digit patterns, dp off
    function automatic logic [7:0] seg_code(input int unsigned digit);
        logic [7:0] pat;
        case (digit)
            0:       pat = 8'hC0;
            1:       pat = 8'hF9;
            2:       pat = 8'hA4;
            3:       pat = 8'hB0;
            4:       pat = 8'h99;
            5:       pat = 8'h92;
            6:       pat = 8'h82;
            7:       pat = 8'hF8;
            8:       pat = 8'h80;
            9:       pat = 8'h98;
            default: pat = 8'hFF;
        endcase
        return pat;
    endfunction

    // Counts one tick of a timed part of a phase; true when the part ends.
    // A saturated timer also ends the part.
    function automatic bit part_done(input logic [pclc_pkg::LEN_WIDTH-1:0] len);
        if (longint'(tick_count) + 1 >= longint'(len) || tick_count == '1)
        begin
            tick_count = '0;
            return 1'b1;
        end
        tick_count = tick_count + 1'b1;
        return 1'b0;
    endfunction

    // Advances the sequencer copy by one tick and returns what the block
    // should show for it (the state at the start of the tick).
    function automatic lamp_state_t step_light(input logic press);
        lamp_state_t  shown;
        int unsigned  sec;
        int unsigned  digit;
        int unsigned  walk_start;

        sec   = (secs_left > pclc_pkg::WALK_MAX) ? 32'(pclc_pkg::WALK_MAX)
                                                 : 32'(secs_left);
        digit = show_units ? (sec % 10) : (sec / 10);

        shown.car_green    = (light_phase == pclc_pkg::PH_GO) ||
                             (light_phase == pclc_pkg::PH_HOLD);
        shown.car_amber    = (light_phase == pclc_pkg::PH_AMBER);
        shown.car_red      = (light_phase == pclc_pkg::PH_WALK);
        shown.walk_green   = (light_phase == pclc_pkg::PH_WALK);
        shown.walk_red     = (light_phase != pclc_pkg::PH_WALK);
        shown.buzzer_on    = (light_phase == pclc_pkg::PH_WALK) && !in_silence;
        shown.digit_select = show_units;
        shown.segments     = seg_code(digit);
        shown.phase_code   = light_phase;
        shown.countdown    = 7'(sec);
        phase_ticks[light_phase]++;

        // press latches before the phase logic looks at it
        if (press)
            crossing_req = 1'b1;

        case (light_phase)
            pclc_pkg::PH_GO:
            begin
                if (crossing_req)
                begin
                    light_phase = pclc_pkg::PH_AMBER;
                    tick_count  = '0;
                end
            end
            pclc_pkg::PH_AMBER:
            begin
                if (part_done(amber_len))
                begin
                    // walk count zero counts as one second, above 99 as 99
                    walk_start = 32'(walk_secs_cfg);
                    if (walk_start == 0)
                        walk_start = 1;
                    if (walk_start > 32'(pclc_pkg::WALK_MAX))
                        walk_start = 32'(pclc_pkg::WALK_MAX);
                    secs_left   = 7'(walk_start);
                    in_silence  = 1'b0;
                    light_phase = pclc_pkg::PH_WALK;
                end
            end
            pclc_pkg::PH_WALK:
            begin
                if (!in_silence)
                begin
                    if (part_done(beep_len))
                        in_silence = 1'b1;
                end
                else if (part_done(quiet_len))
                begin
                    in_silence = 1'b0;
                    if (secs_left > 0)
                        secs_left = secs_left - 1'b1;
                    // end of walk also drops any press taken during it
                    if (secs_left == 0)
                    begin
                        crossing_req = 1'b0;
                        light_phase  = pclc_pkg::PH_HOLD;
                    end
                end
            end
            default:
            begin
                if (part_done(hold_len))
                    light_phase = pclc_pkg::PH_GO;
            end
        endcase

        show_units = !show_units;
        return shown;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what,
                     got, want);
    endtask

    task automatic check_result();
        lamp_state_t want;

        if (pending_lamps.size() == 0)
        begin
            report_mismatch("output transfer with nothing expected", 1, 0);
            return;
        end
        want = pending_lamps.pop_front();
        results_checked++;
        if (car_green !== want.car_green)
            report_mismatch("car_green", longint'(car_green), longint'(want.car_green));
        if (car_amber !== want.car_amber)
            report_mismatch("car_amber", longint'(car_amber), longint'(want.car_amber));
        if (car_red !== want.car_red)
            report_mismatch("car_red", longint'(car_red), longint'(want.car_red));
        if (walk_green !== want.walk_green)
            report_mismatch("walk_green", longint'(walk_green),
                            longint'(want.walk_green));
        if (walk_red !== want.walk_red)
            report_mismatch("walk_red", longint'(walk_red), longint'(want.walk_red));
        if (buzzer_on !== want.buzzer_on)
            report_mismatch("buzzer_on", longint'(buzzer_on), longint'(want.buzzer_on));
        if (digit_select !== want.digit_select)
            report_mismatch("digit_select", longint'(digit_select),
                            longint'(want.digit_select));
        if (segments !== want.segments)
            report_mismatch("segments", longint'(segments), longint'(want.segments));
        if (phase_code !== want.phase_code)
            report_mismatch("phase_code", longint'(phase_code),
                            longint'(want.phase_code));
        if (countdown !== want.countdown)
            report_mismatch("countdown", longint'(countdown), longint'(want.countdown));
    endtask

    // Output side: values read right after the edge are the ones the block
    // saw at that edge, so a transfer is out_valid high with out_stall low.
    // The stall for the next edge is drawn here too.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result();
            out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles, %0d transfers still expected",
                     $realtime, cycle_count, pending_lamps.size());
            $display("** pedestrian_crossing_light_controller: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // Sends one tick. Leaves in_valid high on return so back-to-back ticks
    // never lower and raise it within one time step.
    task automatic send_tick(input logic press);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid     <= 1'b0;
            button_press <= 1'($urandom);   // don't-care while valid is low
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        button_press <= press;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_lamps.push_back(step_light(press));
        ticks_sent++;
    endtask

    // Stops the tick stream and waits until every expected transfer is back,
    // then waits out the DRAIN_SLACK margin for anything still in flight.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_lamps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // Register write, only once the block is idle.
    task automatic write_reg(input logic [pclc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            pclc_pkg::CFG_AMBER:    amber_len     = data;
            pclc_pkg::CFG_BEEP_ON:  beep_len      = data;
            pclc_pkg::CFG_BEEP_OFF: quiet_len     = data;
            pclc_pkg::CFG_WALK:     walk_secs_cfg = data[pclc_pkg::WALK_WIDTH-1:0];
            pclc_pkg::CFG_HOLD:     hold_len      = data;
            default:                ;         // unused index, dropped
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [15:0] amber, input logic [15:0] beep_on,
                             input logic [15:0] beep_off, input logic [15:0] walk,
                             input logic [15:0] hold);
        write_reg(pclc_pkg::CFG_AMBER, amber);
        write_reg(pclc_pkg::CFG_BEEP_ON, beep_on);
        write_reg(pclc_pkg::CFG_BEEP_OFF, beep_off);
        write_reg(pclc_pkg::CFG_WALK, walk);
        write_reg(pclc_pkg::CFG_HOLD, hold);
    endtask

    // mostly short parts so random phases cycle through the whole sequence;
    // now and then zero or a full 16-bit value
    function automatic logic [15:0] pick_len();
        int unsigned roll;

        roll = $urandom_range(99);
        if (roll < 8)
            return 16'd0;
        if (roll < 12)
            return 16'($urandom);
        if (roll < 14)
            return 16'hFFFF;
        return 16'($urandom_range(1, 6));
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // Register defaults after reset: car go, display shows 00, no press.
    task automatic test_reset_state();
        repeat (3) send_tick(1'b0);
    endtask

    // Zero lengths act as one tick each, walk count zero as one second.
    task automatic test_zero_lengths();
        write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_tick(1'b1);
        repeat (9) send_tick(1'b0);
    endtask

    // Walk count above 99 clamps to 99; seconds made of one-tick beep and
    // quiet parts walk the display through every digit pattern on both positions.
    task automatic test_walk_clamp();
        write_all(16'd1, 16'd1, 16'd1, 16'hFFFF, 16'd2);
        send_tick(1'b1);
        repeat (205) send_tick(1'b0);
    endtask

    // Presses during walk are lost at walk end; a press during the hold
    // is kept and served once the hold is over.
    task automatic test_press_in_walk_and_hold();
        write_all(16'd2, 16'd2, 16'd3, 16'd2, 16'd4);
        for (int i = 0; i < 40; i++)
            send_tick(i == 0 || i == 6 || i == 10 || i == 15);
    endtask

    // Writes to indexes past the map must not disturb anything.
    task automatic test_unused_index();
        write_reg(CFG_UNUSED_A, 16'($urandom));
        write_reg(CFG_UNUSED_B, 16'hFFFF);
        write_reg(CFG_UNUSED_C, 16'($urandom));
        for (int i = 0; i < 8; i++)
            send_tick(i[0]);
    endtask

    // Full-scale lengths; the amber part is entered and its timer is still
    // running when the next test writes a new, mostly shorter setting.
    task automatic test_full_scale();
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd99, 16'hFFFF);
        send_tick(1'b1);
        repeat (40) send_tick(1'($urandom));
    endtask

    // Random phases, each with its own setting and press rate. Phase 1 runs
    // with no gaps and no stalls; phase 3 lets the output side run dry in
    // the middle of a sequence.
    task automatic test_random_phases();
        int unsigned press_pct;
        logic [15:0] walk;

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            walk = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
            write_all(pick_len(), pick_len(), pick_len(), walk, pick_len());
            case (p % 3)
                0:       press_pct = 2;
                1:       press_pct = 25;
                default: press_pct = 70;
            endcase
            no_idle = (p == 1);
            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                if (p == 3 && i == PHASE_TICKS / 2)
                    wait_drained();
                send_tick($urandom_range(99) < press_pct);
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_zero_lengths();
        test_walk_clamp();
        test_press_in_walk_and_hold();
        test_unused_index();
        test_full_scale();
        test_random_phases();

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Covered %0d ticks, %0d transfers checked, %0d register writes.",
                 ticks_sent, results_checked, reg_writes);
        $display("Ticks per phase go/amber/walk/hold: %0d/%0d/%0d/%0d, %0d mismatches.",
                 phase_ticks[pclc_pkg::PH_GO], phase_ticks[pclc_pkg::PH_AMBER],
                 phase_ticks[pclc_pkg::PH_WALK], phase_ticks[pclc_pkg::PH_HOLD],
                 err_count);
        if (err_count == 0)
            $display("** pedestrian_crossing_light_controller: PASSED **");
        else
            $display("** pedestrian_crossing_light_controller: FAILED **");
        $finish;
    end

endmodule
